@@ rtl/core/sfr_pkg.sv @@
package sfr_pkg;

  // Sizes of the pattern, the replacement and the compare window
  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam int WIN_DEPTH       = 8;
  localparam int OUT_DEPTH       = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
  } out_item_t;

  // Window cell control: clear wins over shift, shift over append
  typedef struct packed {
    logic clear;
    logic shift;
    logic append;
  } win_ctrl_t;

  // Output cell control: load wins over shift
  typedef struct packed {
    logic load;
    logic shift;
  } out_ctrl_t;

endpackage

@@ rtl/core/sfr_window_cell.sv @@
module sfr_window_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              is_fill,
  input  logic [7:0]        pat_byte,
  input  logic [7:0]        next_e,
  input  sfr_pkg::win_ctrl_t ctrl,
  output logic [7:0]        e,
  output logic              eq
);
  import sfr_pkg::*;

  logic [7:0] held;

  // Take the incoming byte when this cell is the next free slot
  assign e  = is_fill ? in_byte : held;
  assign eq = (e == pat_byte);

  // Clear, shift toward the oldest slot, or keep the appended byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'd0;
    end else begin
      priority if (ctrl.clear) begin
        held <= 8'd0;
      end else if (ctrl.shift) begin
        held <= next_e;
      end else if (ctrl.append) begin
        held <= e;
      end else begin
        held <= held;
      end
    end
  end

endmodule

@@ rtl/core/sfr_out_cell.sv @@
module sfr_out_cell (
  input  logic              clk,
  input  logic [7:0]        load_byte,
  input  logic [7:0]        next_byte,
  input  sfr_pkg::out_ctrl_t ctrl,
  output logic [7:0]        byte_q
);
  import sfr_pkg::*;

  // Load a fresh burst, or advance one place toward the head
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      byte_q <= load_byte;
    end else if (ctrl.shift) begin
      byte_q <= next_byte;
    end else begin
      byte_q <= byte_q;
    end
  end

endmodule

@@ rtl/core/stream_find_and_replace.sv @@
// Streaming find and replace on a byte stream.
// Input channel: in_data carries one character and a last flag; a request is
// taken when in_valid is high and in_stall is low. Output channel: out_data
// carries one character, a byte_valid flag and an end_of_string flag, taken
// when out_valid is high and out_stall is low. Configuration: cfg_valid with
// cfg_ready (always high), cfg_index selects pattern bytes, pattern length,
// replacement bytes or replacement length; writing the pattern length empties
// the window.
// Results of a request appear on the output in the cycle after it is taken.
// Plain text, where each request yields at most one result, flows at one byte
// per cycle while the receiver does not stall; a request that yields k results
// (a replacement, or the flush of the window at end of string) holds the input
// while the output cell chain drains one result per cycle, as the receiver takes
// them. The next request is taken in the cycle the final pending result leaves.
// While the receiver stalls, the head result holds and in_stall stays high
// as long as any result is pending.
// Reset empties the window and the output chain and clears the configuration.
module stream_find_and_replace (
  input  logic                             clk,
  input  logic                             rst,
  input  sfr_pkg::in_item_t                in_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  output sfr_pkg::out_item_t               out_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfr_pkg::*;

  // Configuration registers
  logic [8*PATTERN_MAX-1:0]     pattern_bytes;
  logic [LEN_W-1:0]             pattern_length;
  logic [8*REPLACEMENT_MAX-1:0] replacement_bytes;
  logic [LEN_W-1:0]             replacement_length;

  // Window and output chain state
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] fill_next;
  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] count_next;
  logic             burst_last;
  logic             burst_marker;

  logic             cfg_fire;
  logic             plen_write;
  logic             in_fire;
  logic             out_fire;

  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic [LEN_W-1:0] fill_inc;
  logic             compare;
  logic             match;
  logic             marker;
  logic [LEN_W-1:0] burst_count;

  logic [7:0]       win_e [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_eq;
  logic [WIN_DEPTH-1:0] win_mask;
  win_ctrl_t        win_ctrl;

  logic [7:0]       out_q [OUT_DEPTH];
  out_ctrl_t        out_ctrl;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign plen_write = cfg_fire && (cfg_index_t'(cfg_index) == CFG_PATTERN_LENGTH);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PATTERN_BYTES:      pattern_bytes      <= cfg_data[8*PATTERN_MAX-1:0];
        CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data[8*REPLACEMENT_MAX-1:0];
        CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp lengths to the supported maxima
  assign plen = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                       : pattern_length;
  assign rlen = (replacement_length > LEN_W'(REPLACEMENT_MAX)) ? LEN_W'(REPLACEMENT_MAX)
                                                               : replacement_length;

  // Handshakes: take a request only when the chain is empty or emptying
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = !((count == '0) || ((count == LEN_W'(1)) && !out_stall));
  assign in_fire   = in_valid && !in_stall;

  // Window chain of compare cells
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
    logic [7:0] next_e;
    if (i == WIN_DEPTH - 1) begin : g_end
      assign next_e = 8'd0;
    end else begin : g_mid
      assign next_e = win_e[i+1];
    end
    assign win_mask[i] = (LEN_W'(i) < plen);
    sfr_window_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_byte  (in_data.in_byte),
      .is_fill  (fill == LEN_W'(i)),
      .pat_byte (pattern_bytes[8*i +: 8]),
      .next_e   (next_e),
      .ctrl     (win_ctrl),
      .e        (win_e[i]),
      .eq       (win_eq[i])
    );
  end

  // Compare once the window reaches the pattern length
  assign fill_inc = fill + LEN_W'(1);
  assign compare  = (plen != '0) && (fill_inc >= plen);
  assign match    = compare && (&(win_eq | ~win_mask));

  // Size the burst of results for this request
  always_comb begin
    priority if (plen == '0) begin
      burst_count = LEN_W'(1);
    end else if (match) begin
      burst_count = rlen;
    end else if (compare) begin
      burst_count = in_data.in_last ? plen : LEN_W'(1);
    end else begin
      burst_count = in_data.in_last ? fill_inc : '0;
    end
  end

  assign marker = in_data.in_last && (burst_count == '0);

  // Steer the window: clear, drop the oldest byte, or append
  always_comb begin
    win_ctrl  = '0;
    fill_next = fill;
    if (plen_write) begin
      win_ctrl.clear = 1'b1;
      fill_next      = '0;
    end else if (in_fire && (plen != '0)) begin
      priority if (in_data.in_last || match) begin
        win_ctrl.clear = 1'b1;
        fill_next      = '0;
      end else if (compare) begin
        win_ctrl.shift = 1'b1;
        fill_next      = plen - LEN_W'(1);
      end else begin
        win_ctrl.append = 1'b1;
        fill_next       = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Output chain: load a burst, then shift one result out per result the receiver takes
  assign out_ctrl.load  = in_fire;
  assign out_ctrl.shift = out_fire;

  for (genvar i = 0; i < OUT_DEPTH; i++) begin : g_out
    logic [7:0] load_byte;
    logic [7:0] next_byte;
    if (i == OUT_DEPTH - 1) begin : g_end
      assign next_byte = 8'd0;
    end else begin : g_mid
      assign next_byte = out_q[i+1];
    end
    assign load_byte = marker ? 8'd0 :
                       match  ? replacement_bytes[8*i +: 8] : win_e[i];
    sfr_out_cell u_cell (
      .clk       (clk),
      .load_byte (load_byte),
      .next_byte (next_byte),
      .ctrl      (out_ctrl),
      .byte_q    (out_q[i])
    );
  end

  // Track results pending in the chain
  always_comb begin
    count_next = count;
    priority if (in_fire) begin
      count_next = marker ? LEN_W'(1) : burst_count;
    end else if (out_fire) begin
      count_next = count - LEN_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      burst_last   <= 1'b0;
      burst_marker <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        burst_last   <= in_data.in_last;
        burst_marker <= marker;
      end
    end
  end

  assign out_data.out_byte      = out_q[0];
  assign out_data.byte_valid    = !burst_marker;
  assign out_data.end_of_string = burst_last && (count == LEN_W'(1));

endmodule
